@@ sv/brcs_pkg.sv @@
// ----------------------------------------------------------------------------
// brcs_pkg - blitter rectangle clip setup package
// Request and result beat layouts and the fixed blitter control constants.
// ----------------------------------------------------------------------------
`default_nettype none

package brcs_pkg;

    // channel enables plus the cookie-cut minterm
    localparam logic [15:0] CON0_COOKIE = 16'h07CA;
    // channel A enable when a mask plane is used
    localparam logic [15:0] CON0_SRCA   = 16'h0800;
    localparam logic [15:0] WORD_ALL    = 16'hFFFF;
    localparam logic [15:0] WORD_NONE   = 16'h0000;

    // one copy request
    typedef struct packed {
        logic [14:0]        src_x;
        logic [14:0]        src_y;
        logic signed [15:0] dst_x;
        logic signed [15:0] dst_y;
        logic [10:0]        rect_width;
        logic [10:0]        rect_height;
        logic [14:0]        dest_map_width;
        logic [14:0]        dest_map_height;
        logic [11:0]        src_bytes_per_row;
        logic [11:0]        dst_bytes_per_row;
        logic               has_mask;
    } req_t;

    // one set of register words
    typedef struct packed {
        logic        fully_clipped;
        logic [15:0] control_word0;
        logic [15:0] control_word1;
        logic [15:0] first_word_mask;
        logic [15:0] last_word_mask;
        logic [15:0] source_modulo;
        logic [15:0] dest_modulo;
        logic [15:0] mask_modulo;
        logic [15:0] size_word;
        logic [31:0] source_offset;
        logic [31:0] dest_offset;
        logic [15:0] mask_fill;
    } res_t;

endpackage

`default_nettype wire

@@ sv/blit_rect_clip_setup.sv @@
// ----------------------------------------------------------------------------
// blit_rect_clip_setup - planar blitter copy setup with destination clipping
// Clips one rectangle-copy request against the destination bitmap and forms
// the offsets, masks, shift, modulos and size word of a cookie-cut blit.
// ----------------------------------------------------------------------------
`default_nettype none

// Takes one request beat per cycle while m_ready does not stall the result
// channel and returns one result beat per request, in order. A request is
// captured in an input register on the cycle it is accepted; the clip, word
// arithmetic and the two row-pitch multiplies are computed from that input
// register and captured in the result register when that frees up. The
// rate is one request per cycle, set by the input and result registers:
// s_ready follows m_ready whenever both registers are occupied. A request
// left with no width or height after clipping gives fully_clipped with all
// other fields zero.
module blit_rect_clip_setup (
    input  wire                aclk,
    input  wire                aresetn,
    // request channel
    input  wire                s_valid,
    output logic               s_ready,
    input  wire  [14:0]        s_src_x,
    input  wire  [14:0]        s_src_y,
    input  wire  signed [15:0] s_dst_x,
    input  wire  signed [15:0] s_dst_y,
    input  wire  [10:0]        s_rect_width,
    input  wire  [10:0]        s_rect_height,
    input  wire  [14:0]        s_dest_map_width,
    input  wire  [14:0]        s_dest_map_height,
    input  wire  [11:0]        s_src_bytes_per_row,
    input  wire  [11:0]        s_dst_bytes_per_row,
    input  wire                s_has_mask,
    // result channel
    output logic               m_valid,
    input  wire                m_ready,
    output logic               m_fully_clipped,
    output logic [15:0]        m_control_word0,
    output logic [15:0]        m_control_word1,
    output logic [15:0]        m_first_word_mask,
    output logic [15:0]        m_last_word_mask,
    output logic signed [15:0] m_source_modulo,
    output logic signed [15:0] m_dest_modulo,
    output logic signed [15:0] m_mask_modulo,
    output logic [15:0]        m_size_word,
    output logic [31:0]        m_source_offset,
    output logic [31:0]        m_dest_offset,
    output logic [15:0]        m_mask_fill
);

    brcs_pkg::req_t req_reg;
    logic           req_valid_reg;
    logic           req_valid_next;
    brcs_pkg::res_t res_reg;
    brcs_pkg::res_t res_next;
    logic           res_valid_reg;
    logic           res_valid_next;
    logic           advance;

    // clip arithmetic
    logic signed [17:0] dx_ext, dy_ext;
    logic signed [17:0] sx_ext, sy_ext;
    logic signed [17:0] iw_ext, ih_ext;
    logic signed [17:0] bmw_ext, bmh_ext;
    logic signed [17:0] w_clip, h_clip;
    logic signed [17:0] sx_clip, sy_clip;
    logic signed [17:0] dx_clip, dy_clip;
    logic               clipped;

    // word arithmetic
    logic [15:0] sx16;
    logic [14:0] dx15;
    logic [15:0] sy16;
    logic [14:0] dy15;
    logic [15:0] nw;
    logic [15:0] swe, dwe;
    logic [15:0] sws, dws;
    logic [15:0] sbw, dbw, bw;
    logic        neg_shift;
    logic [3:0]  shift;
    logic [3:0]  sbe;
    logic [15:0] lmask;
    logic [27:0] sprod;
    logic [26:0] dprod;
    logic [31:0] soff, doff;
    logic [15:0] smod, dmod;
    logic [15:0] con0;

    // handshake: result register frees up when empty or being taken
    assign advance        = req_valid_reg && (!res_valid_reg || m_ready);
    assign s_ready        = !req_valid_reg || advance;
    assign req_valid_next = s_valid ? 1'b1 : (advance ? 1'b0 : req_valid_reg);
    assign res_valid_next = advance ? 1'b1 : ((res_valid_reg && m_ready) ? 1'b0
                                                                        : res_valid_reg);

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                req_valid_reg <= req_valid_next;
            end else begin
                req_valid_reg <= req_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg.src_x             <= s_src_x;
            req_reg.src_y             <= s_src_y;
            req_reg.dst_x             <= s_dst_x;
            req_reg.dst_y             <= s_dst_y;
            req_reg.rect_width        <= s_rect_width;
            req_reg.rect_height       <= s_rect_height;
            req_reg.dest_map_width    <= s_dest_map_width;
            req_reg.dest_map_height   <= s_dest_map_height;
            req_reg.src_bytes_per_row <= s_src_bytes_per_row;
            req_reg.dst_bytes_per_row <= s_dst_bytes_per_row;
            req_reg.has_mask          <= s_has_mask;
        end
    end

    // sign and zero extension to a common width
    always_comb begin
        dx_ext  = {{2{req_reg.dst_x[15]}}, req_reg.dst_x};
        dy_ext  = {{2{req_reg.dst_y[15]}}, req_reg.dst_y};
        sx_ext  = {3'd0, req_reg.src_x};
        sy_ext  = {3'd0, req_reg.src_y};
        iw_ext  = {7'd0, req_reg.rect_width};
        ih_ext  = {7'd0, req_reg.rect_height};
        bmw_ext = {3'd0, req_reg.dest_map_width};
        bmh_ext = {3'd0, req_reg.dest_map_height};
    end

    // horizontal clip: left edge first, else right overhang
    always_comb begin
        w_clip  = iw_ext;
        sx_clip = sx_ext;
        dx_clip = dx_ext;
        if (dx_ext[17]) begin
            w_clip  = iw_ext + dx_ext;
            sx_clip = sx_ext - dx_ext;
            dx_clip = '0;
        end else if (dx_ext > (bmw_ext - iw_ext)) begin
            w_clip = bmw_ext - dx_ext;
        end
    end

    // vertical clip: top edge first, else bottom overhang
    always_comb begin
        h_clip  = ih_ext;
        sy_clip = sy_ext;
        dy_clip = dy_ext;
        if (dy_ext[17]) begin
            h_clip  = ih_ext + dy_ext;
            sy_clip = sy_ext - dy_ext;
            dy_clip = '0;
        end else if (dy_ext > (bmh_ext - ih_ext)) begin
            h_clip = bmh_ext - dy_ext;
        end
    end

    assign clipped = w_clip[17] || (w_clip == '0) || h_clip[17] || (h_clip == '0);

    // word positions, widths and shift
    always_comb begin
        sx16      = sx_clip[15:0];
        dx15      = dx_clip[14:0];
        sy16      = sy_clip[15:0];
        dy15      = dy_clip[14:0];
        nw        = w_clip[15:0] - 16'd1;
        swe       = sx16 + nw;
        dwe       = {1'b0, dx15} + nw;
        sws       = {4'd0, sx16[15:4]};
        dws       = {5'd0, dx15[14:4]};
        sbw       = {4'd0, swe[15:4]} - sws + 16'd1;
        dbw       = {4'd0, dwe[15:4]} - dws + 16'd1;
        bw        = (sbw > dbw) ? sbw : dbw;
        neg_shift = dx15[3:0] < sx16[3:0];
        shift     = dx15[3:0] - sx16[3:0];
        sbe       = swe[3:0];
        if (neg_shift || (dbw > sbw)) begin
            lmask = brcs_pkg::WORD_NONE;
        end else begin
            lmask = brcs_pkg::WORD_ALL << (4'd15 - sbe);
        end
    end

    // byte offsets and modulos
    always_comb begin
        sprod = sy16 * req_reg.src_bytes_per_row;
        dprod = dy15 * req_reg.dst_bytes_per_row;
        soff  = {4'd0, sprod} + {19'd0, sws[11:0], 1'b0};
        doff  = {5'd0, dprod} + {20'd0, dws[10:0], 1'b0}
                - (neg_shift ? 32'd2 : 32'd0);
        smod  = {4'd0, req_reg.src_bytes_per_row} - {bw[14:0], 1'b0};
        dmod  = {4'd0, req_reg.dst_bytes_per_row} - {bw[14:0], 1'b0};
        con0  = {shift, 12'd0} | brcs_pkg::CON0_COOKIE
                | (req_reg.has_mask ? brcs_pkg::CON0_SRCA : brcs_pkg::WORD_NONE);
    end

    // result assembly
    always_comb begin
        res_next = '0;
        if (clipped) begin
            res_next.fully_clipped = 1'b1;
        end else begin
            res_next.control_word0   = con0;
            res_next.control_word1   = {shift, 12'd0};
            res_next.first_word_mask = brcs_pkg::WORD_ALL >> sx16[3:0];
            res_next.last_word_mask  = lmask;
            res_next.source_modulo   = smod;
            res_next.dest_modulo     = dmod;
            res_next.mask_modulo     = req_reg.has_mask ? smod : brcs_pkg::WORD_NONE;
            res_next.size_word       = {h_clip[9:0], 6'd0} | bw;
            res_next.source_offset   = soff;
            res_next.dest_offset     = doff;
            res_next.mask_fill       = req_reg.has_mask ? brcs_pkg::WORD_NONE
                                                        : brcs_pkg::WORD_ALL;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    // result ports
    assign m_valid           = res_valid_reg;
    assign m_fully_clipped   = res_reg.fully_clipped;
    assign m_control_word0   = res_reg.control_word0;
    assign m_control_word1   = res_reg.control_word1;
    assign m_first_word_mask = res_reg.first_word_mask;
    assign m_last_word_mask  = res_reg.last_word_mask;
    assign m_source_modulo   = $signed(res_reg.source_modulo);
    assign m_dest_modulo     = $signed(res_reg.dest_modulo);
    assign m_mask_modulo     = $signed(res_reg.mask_modulo);
    assign m_size_word       = res_reg.size_word;
    assign m_source_offset   = res_reg.source_offset;
    assign m_dest_offset     = res_reg.dest_offset;
    assign m_mask_fill       = res_reg.mask_fill;

    // a clipped beat carries no register words
    a_clipped_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_fully_clipped) |-> (m_control_word0 == 16'd0 &&
            m_first_word_mask == 16'd0 && m_mask_fill == 16'd0 &&
            m_source_offset == 32'd0 && m_dest_offset == 32'd0))
        else $error("clipped beat carries non-zero words");

    // both control words share the shift nibble, minterm always present
    a_control_words: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_fully_clipped) |-> (m_control_word0[15:12] == m_control_word1[15:12]
            && m_control_word1[11:0] == 12'd0
            && (m_control_word0[11:0] == 12'h7CA || m_control_word0[11:0] == 12'hFCA)))
        else $error("control words inconsistent");

    // a waiting request moves into an empty result register
    a_forward: assert property (@(posedge aclk) disable iff (!aresetn)
        (req_valid_reg && !res_valid_reg) |=> res_valid_reg)
        else $error("request not forwarded to result register");

    // the mask fill word agrees with the mask modulo choice
    a_mask_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_fully_clipped && m_mask_fill == 16'hFFFF) |-> (m_mask_modulo == 16'sd0))
        else $error("mask fill and mask modulo disagree");

endmodule

`default_nettype wire
